// ----- sv/bmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Barometric compensation package
// Shared widths, register indexes, the calibration coefficient bundle and
// small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpc_pkg;

    localparam int RAW_W   = 20;
    localparam int WORD_W  = 32;
    localparam int CFG_W   = 64;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 72;
    localparam int SIDE_W  = WORD_W + 2;

    localparam logic [31:0] P_OFFSET   = 32'd64000;
    localparam logic [31:0] RAW_FULL   = 32'd1048576;
    localparam logic [31:0] P_SCALE    = 32'd3125;
    localparam logic [31:0] P1_OFFSET  = 32'd32768;
    localparam logic [31:0] T_ROUND    = 32'd128;

    typedef enum logic [1:0] {
        CFG_TEMP   = 2'd0,
        CFG_PLOW   = 2'd1,
        CFG_PHIGH  = 2'd2,
        CFG_PNINE  = 2'd3
    } cfg_idx_t;

    // Calibration words, each widened to a 32-bit word as the arithmetic uses it.
    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] p5;
        logic [31:0] p6;
        logic [31:0] p7;
        logic [31:0] p8;
        logic [31:0] p9;
    } coef_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] zx16(input logic [15:0] v);
        return {16'd0, v};
    endfunction

endpackage

`default_nettype wire

// ----- sv/barometric_sensor_compensation.sv -----
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Integer temperature and pressure compensation from raw 20-bit readings.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata[19:0] raw_temperature, tdata[39:20] raw_pressure
// m_axis    out        tdata[31:0] temperature_centi, [63:32] pressure_pascal,
//                      [64] pressure_invalid, [71:65] zero
// cfg       in         cfg_we, cfg_index, cfg_data (calibration words)
//
// One reading pair enters per cycle unless the output stalls. The result
// goes through a 32-stage divider that forms one quotient bit per stage.
// Reset clears the valid bits and the calibration registers.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_sensor_compensation
    import bmpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,   // raw_temperature, raw_pressure
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,   // temperature_centi, pressure_pascal,
                                                   // pressure_invalid
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    logic [47:0] temp_coeffs_reg;
    logic [63:0] pres_low_reg;
    logic [63:0] pres_high_reg;
    logic [15:0] pres_nine_reg;
    coef_t       coef;
    logic        en;

    logic              t_v;
    logic [31:0]       t_temp, t_pu;
    logic [RAW_W-1:0]  t_rp;
    logic              p_v;
    logic [31:0]       p_dvd, p_den;
    logic [SIDE_W-1:0] p_side;
    logic              d_v;
    logic [31:0]       d_quo;
    logic [SIDE_W-1:0] d_side;
    logic [31:0]       o_temp, o_pres;
    logic              o_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            pres_low_reg    <= '0;
            pres_high_reg   <= '0;
            pres_nine_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TEMP:  temp_coeffs_reg <= cfg_data[47:0];
                CFG_PLOW:  pres_low_reg    <= cfg_data;
                CFG_PHIGH: pres_high_reg   <= cfg_data;
                CFG_PNINE: pres_nine_reg   <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        coef.t1 = zx16(temp_coeffs_reg[15:0]);
        coef.t2 = sx16(temp_coeffs_reg[31:16]);
        coef.t3 = sx16(temp_coeffs_reg[47:32]);
        coef.p1 = zx16(pres_low_reg[15:0]);
        coef.p2 = sx16(pres_low_reg[31:16]);
        coef.p3 = sx16(pres_low_reg[47:32]);
        coef.p4 = sx16(pres_low_reg[63:48]);
        coef.p5 = sx16(pres_high_reg[15:0]);
        coef.p6 = sx16(pres_high_reg[31:16]);
        coef.p7 = sx16(pres_high_reg[47:32]);
        coef.p8 = sx16(pres_high_reg[63:48]);
        coef.p9 = sx16(pres_nine_reg);
    end

    // The pipeline moves whenever the output register is empty or being taken.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    bmpc_temp u_temp (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vin    (s_axis_tvalid),
        .rt     (s_axis_tdata[19:0]),
        .rp     (s_axis_tdata[39:20]),
        .coef   (coef),
        .vout   (t_v),
        .temp_o (t_temp),
        .pu_o   (t_pu),
        .rp_o   (t_rp)
    );

    bmpc_pres u_pres (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vin    (t_v),
        .temp_i (t_temp),
        .pu     (t_pu),
        .rp     (t_rp),
        .coef   (coef),
        .vout   (p_v),
        .dvd_o  (p_dvd),
        .den_o  (p_den),
        .side_o (p_side)
    );

    bmpc_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vin    (p_v),
        .dvd    (p_dvd),
        .den    (p_den),
        .side_i (p_side),
        .vout   (d_v),
        .quo    (d_quo),
        .side_o (d_side)
    );

    bmpc_post u_post (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vin    (d_v),
        .quo    (d_quo),
        .side_i (d_side),
        .coef   (coef),
        .vout   (m_axis_tvalid),
        .temp_o (o_temp),
        .pres_o (o_pres),
        .bad_o  (o_bad)
    );

    assign m_axis_tdata = {7'd0, o_bad, o_pres, o_temp};

endmodule

`default_nettype wire

// ----- sv/bmpc_temp.sv -----
// ----------------------------------------------------------------------------
// Temperature stages
// Five register stages forming the fine-temperature term, the compensated
// temperature and the offset pressure-path term.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpc_temp
    import bmpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              vin,
    input  wire logic [RAW_W-1:0]  rt,
    input  wire logic [RAW_W-1:0]  rp,
    input  wire coef_t             coef,
    output logic                   vout,
    output logic [31:0]            temp_o,
    output logic [31:0]            pu_o,
    output logic [RAW_W-1:0]       rp_o
);

    logic [4:0]       v_reg;
    logic [RAW_W-1:0] rp_reg [0:4];

    logic [31:0] a_reg, d_reg;
    logic [31:0] m1_reg, dd_reg;
    logic [31:0] u_reg, m3_reg;
    logic [31:0] fine_reg;
    logic [31:0] temp_reg, pu_reg;

    logic [31:0] rt32;
    logic [31:0] a_next, d_next, m1_next, dd_next, u_next, m3_next, fine_next;
    logic [31:0] t5, temp_next, pu_next;

    always_comb
    begin
        rt32      = {12'd0, rt};
        a_next    = (rt32 >> 3) - (coef.t1 << 1);
        d_next    = (rt32 >> 4) - coef.t1;
        m1_next   = a_reg * coef.t2;
        dd_next   = d_reg * d_reg;
        u_next    = 32'($signed(m1_reg) >>> 11);
        m3_next   = 32'($signed(dd_reg) >>> 12) * coef.t3;
        fine_next = u_reg + 32'($signed(m3_reg) >>> 14);
        t5        = (fine_reg << 2) + fine_reg + T_ROUND;
        temp_next = 32'($signed(t5) >>> 8);
        pu_next   = 32'($signed(fine_reg) >>> 1) - P_OFFSET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], vin};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp_reg[0] <= rp;
            rp_reg[1] <= rp_reg[0];
            rp_reg[2] <= rp_reg[1];
            rp_reg[3] <= rp_reg[2];
            rp_reg[4] <= rp_reg[3];
            a_reg     <= a_next;
            d_reg     <= d_next;
            m1_reg    <= m1_next;
            dd_reg    <= dd_next;
            u_reg     <= u_next;
            m3_reg    <= m3_next;
            fine_reg  <= fine_next;
            temp_reg  <= temp_next;
            pu_reg    <= pu_next;
        end
    end

    assign vout   = v_reg[4];
    assign temp_o = temp_reg;
    assign pu_o   = pu_reg;
    assign rp_o   = rp_reg[4];

endmodule

`default_nettype wire

// ----- sv/bmpc_pres.sv -----
// ----------------------------------------------------------------------------
// Pressure numerator and denominator stages
// Six register stages producing the divider operands and the zero
// denominator flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpc_pres
    import bmpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              vin,
    input  wire logic [31:0]       temp_i,
    input  wire logic [31:0]       pu,
    input  wire logic [RAW_W-1:0]  rp,
    input  wire coef_t             coef,
    output logic                   vout,
    output logic [31:0]            dvd_o,
    output logic [31:0]            den_o,
    output logic [SIDE_W-1:0]      side_o
);

    logic [5:0]       v_reg;
    logic [31:0]      temp_reg [0:5];
    logic [RAW_W-1:0] rp_reg [0:3];

    logic [31:0] sq_reg, up5_reg, p2u_reg;
    logic [31:0] w1_reg, m3_reg, up5b_reg, p2ub_reg;
    logic [31:0] w_reg, v_w_reg;
    logic [31:0] x_reg, nb_reg;
    logic [31:0] den_reg, num_reg;
    logic [31:0] dvd_reg, den2_reg;
    logic        bad_reg, big_reg;

    logic [31:0] q, sq_next, w1_next, m3_next, w_sum, w_next, v_sum, v_next;
    logic [31:0] x_next, nb_next;

    always_comb
    begin
        q       = 32'($signed(pu) >>> 2);
        sq_next = q * q;
        w1_next = 32'($signed(sq_reg) >>> 11) * coef.p6;
        m3_next = coef.p3 * 32'($signed(sq_reg) >>> 13);
        w_sum   = w1_reg + (up5b_reg << 1);
        w_next  = 32'($signed(w_sum) >>> 2) + (coef.p4 << 16);
        v_sum   = 32'($signed(m3_reg) >>> 3) + 32'($signed(p2ub_reg) >>> 1);
        v_next  = 32'($signed(v_sum) >>> 18);
        x_next  = (P1_OFFSET + v_w_reg) * coef.p1;
        nb_next = (RAW_FULL - {12'd0, rp_reg[2]}) - 32'($signed(w_reg) >>> 12);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], vin};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg[0] <= temp_i;
            for (int i = 1; i < 6; i++)
            begin
                temp_reg[i] <= temp_reg[i-1];
            end
            rp_reg[0] <= rp;
            for (int i = 1; i < 4; i++)
            begin
                rp_reg[i] <= rp_reg[i-1];
            end
            sq_reg   <= sq_next;
            up5_reg  <= pu * coef.p5;
            p2u_reg  <= coef.p2 * pu;
            w1_reg   <= w1_next;
            m3_reg   <= m3_next;
            up5b_reg <= up5_reg;
            p2ub_reg <= p2u_reg;
            w_reg    <= w_next;
            v_w_reg  <= v_next;
            x_reg    <= x_next;
            nb_reg   <= nb_next;
            den_reg  <= 32'($signed(x_reg) >>> 15);
            num_reg  <= nb_reg * P_SCALE;
            // A numerator with its top bit set is divided first and doubled later.
            big_reg  <= num_reg[31];
            dvd_reg  <= num_reg[31] ? num_reg : (num_reg << 1);
            den2_reg <= den_reg;
            bad_reg  <= (den_reg == 32'd0);
        end
    end

    assign vout   = v_reg[5];
    assign dvd_o  = dvd_reg;
    assign den_o  = den2_reg;
    assign side_o = {big_reg, bad_reg, temp_reg[5]};

endmodule

`default_nettype wire

// ----- sv/bmpc_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined divider
// Unsigned 32-bit restoring division, one quotient bit per register stage,
// with a side payload carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpc_div
    import bmpc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               vin,
    input  wire logic [WORD_W-1:0]  dvd,
    input  wire logic [WORD_W-1:0]  den,
    input  wire logic [SIDE_W-1:0]  side_i,
    output logic                    vout,
    output logic [WORD_W-1:0]       quo,
    output logic [SIDE_W-1:0]       side_o
);

    logic [WORD_W-1:0] rem_reg [0:WORD_W-1];
    logic [WORD_W-1:0] qd_reg  [0:WORD_W-1];
    logic [WORD_W-1:0] dv_reg  [0:WORD_W-1];
    logic [SIDE_W-1:0] sd_reg  [0:WORD_W-1];
    logic [WORD_W-1:0] v_reg;

    logic [WORD_W-1:0] rem_w [0:WORD_W-1];
    logic [WORD_W-1:0] qd_w  [0:WORD_W-1];
    logic [WORD_W-1:0] dv_w  [0:WORD_W-1];
    logic [SIDE_W-1:0] sd_w  [0:WORD_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[WORD_W-2:0], vin};
        end
    end

    for (genvar k = 0; k < WORD_W; k++)
    begin : g_stage
        logic [WORD_W:0]   sh;
        logic              ge;
        logic [WORD_W:0]   diff;

        if (k == 0)
        begin : g_first
            assign rem_w[k] = '0;
            assign qd_w[k]  = dvd;
            assign dv_w[k]  = den;
            assign sd_w[k]  = side_i;
        end
        else
        begin : g_next
            assign rem_w[k] = rem_reg[k-1];
            assign qd_w[k]  = qd_reg[k-1];
            assign dv_w[k]  = dv_reg[k-1];
            assign sd_w[k]  = sd_reg[k-1];
        end

        assign sh   = {rem_w[k], qd_w[k][WORD_W-1]};
        assign diff = sh - {1'b0, dv_w[k]};
        assign ge   = (sh >= {1'b0, dv_w[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[WORD_W-1:0] : sh[WORD_W-1:0];
                qd_reg[k]  <= {qd_w[k][WORD_W-2:0], ge};
                dv_reg[k]  <= dv_w[k];
                sd_reg[k]  <= sd_w[k];
            end
        end
    end

    assign vout   = v_reg[WORD_W-1];
    assign quo    = qd_reg[WORD_W-1];
    assign side_o = sd_reg[WORD_W-1];

endmodule

`default_nettype wire

// ----- sv/bmpc_post.sv -----
// ----------------------------------------------------------------------------
// Pressure correction stages
// Three register stages applying the second-order P7..P9 correction; the
// last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpc_post
    import bmpc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               vin,
    input  wire logic [WORD_W-1:0]  quo,
    input  wire logic [SIDE_W-1:0]  side_i,
    input  wire coef_t              coef,
    output logic                    vout,
    output logic [31:0]             temp_o,
    output logic [31:0]             pres_o,
    output logic                    bad_o
);

    logic [2:0]  v_reg;
    logic [31:0] temp_reg [0:2];
    logic [2:0]  bad_reg;
    logic [31:0] pres_reg, pres2_reg, qq_reg;
    logic [31:0] m_reg, n_reg;
    logic [31:0] fin_reg;

    logic [31:0] pres_next, q, corr, fin_next;

    always_comb
    begin
        pres_next = side_i[WORD_W+1] ? (quo << 1) : quo;
        q         = pres_next >> 3;
        corr      = 32'($signed(m_reg) >>> 12) + 32'($signed(n_reg) >>> 13) + coef.p7;
        fin_next  = bad_reg[1] ? 32'd0 : (pres2_reg + 32'($signed(corr) >>> 4));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], vin};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg[0] <= side_i[WORD_W-1:0];
            temp_reg[1] <= temp_reg[0];
            temp_reg[2] <= temp_reg[1];
            bad_reg     <= {bad_reg[1:0], side_i[WORD_W]};
            pres_reg    <= pres_next;
            qq_reg      <= q * q;
            m_reg       <= coef.p9 * (qq_reg >> 13);
            n_reg       <= (pres_reg >> 2) * coef.p8;
            pres2_reg   <= pres_reg;
            fin_reg     <= fin_next;
        end
    end

    assign vout   = v_reg[2];
    assign temp_o = temp_reg[2];
    assign pres_o = fin_reg;
    assign bad_o  = bad_reg[2];

endmodule

`default_nettype wire

// ----- sv/bmpc_checker.sv -----
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for output hold, flow control and result
// encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpc_checker
    import bmpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tready,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [OUT_W-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output space");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[63:32] == 32'd0)
        else $error("invalid pressure is not zero");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:65] == 7'd0)
        else $error("padding bits set");

endmodule

bind barometric_sensor_compensation bmpc_checker u_bmpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometric compensation testbench
// Drives raw reading pairs over the input stream under several calibration
// sets, predicts each compensated result and checks every output transfer.
// ----------------------------------------------------------------------------

module tb_top;
    import bmpc_pkg::*;

    localparam int N_RANDOM  = 1600;
    localparam int DOG_LIMIT = 20000;
    localparam int LATENCY   = 46;

    typedef struct packed {
        logic        invalid;
        logic [31:0] pascal;
        logic [31:0] centi;
    } comp_t;

    typedef struct {
        logic [19:0] rt;
        logic [19:0] rp;
        bit          has_exp;
        comp_t       exp;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // raw_temperature, raw_pressure
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // temperature_centi, pressure_pascal, pressure_invalid
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    logic [47:0] cal_temp;
    logic [63:0] cal_plow;
    logic [63:0] cal_phigh;
    logic [15:0] cal_p9;

    comp_t pending_results[$];
    int    n_errors;
    int    idle_cycles;
    bit    no_idle;

    barometric_sensor_compensation i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] asr(input logic [31:0] x, input int s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] s16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic comp_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
        logic [31:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] u, w, d, q, sq, fine, pres;
        comp_t r;
        rt = {12'd0, raw_t};
        rp = {12'd0, raw_p};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = s16(cal_temp[31:16]);
        t3 = s16(cal_temp[47:32]);
        p1 = {16'd0, cal_plow[15:0]};
        p2 = s16(cal_plow[31:16]);
        p3 = s16(cal_plow[47:32]);
        p4 = s16(cal_plow[63:48]);
        p5 = s16(cal_phigh[15:0]);
        p6 = s16(cal_phigh[31:16]);
        p7 = s16(cal_phigh[47:32]);
        p8 = s16(cal_phigh[63:48]);
        p9 = s16(cal_p9);
        u = asr(((rt >> 3) - (t1 << 1)) * t2, 11);
        d = (rt >> 4) - t1;
        w = asr(asr(d * d, 12) * t3, 14);
        fine = u + w;
        r.centi = asr(fine * 32'd5 + 32'd128, 8);
        u = asr(fine, 1) - 32'd64000;
        q = asr(u, 2);
        sq = q * q;
        w = asr(sq, 11) * p6;
        w = w + ((u * p5) << 1);
        w = asr(w, 2) + (p4 << 16);
        u = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * u, 1), 18);
        u = asr((32'd32768 + u) * p1, 15);
        r.invalid = (u == 32'd0);
        r.pascal = 32'd0;
        if (!r.invalid)
        begin
            pres = ((32'd1048576 - rp) - asr(w, 12)) * 32'd3125;
            if (pres < 32'h80000000)
                pres = (pres << 1) / u;
            else
                pres = (pres / u) * 32'd2;
            q = pres >> 3;
            d = asr(p9 * ((q * q) >> 13), 12);
            w = asr((pres >> 2) * p8, 13);
            r.pascal = pres + asr(d + w + p7, 4);
        end
        return r;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_TEMP:  cal_temp  = value[47:0];
            CFG_PLOW:  cal_plow  = value;
            CFG_PHIGH: cal_phigh = value;
            CFG_PNINE: cal_p9    = value[15:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_cal(input logic [47:0] t, input logic [63:0] pl,
                            input logic [63:0] ph, input logic [15:0] p9);
        write_reg(CFG_TEMP, {16'hFFFF, t});
        write_reg(CFG_PLOW, pl);
        write_reg(CFG_PHIGH, ph);
        write_reg(CFG_PNINE, {48'hFFFF_FFFF_FFFF, p9});
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // One input transfer; the expectation is queued at the accepting edge.
    // The valid line drops only when the sender idles or the bench drains or holds
    // off, so back-to-back transfers keep it high.
    task automatic send_pair(input logic [19:0] rt, input logic [19:0] rp,
                             input bit has_exp, input comp_t exp);
        if (!no_idle && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 29)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rp, rt};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(has_exp ? exp : compensate(rt, rp));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);
    end

    always @(posedge clk)
    begin
        comp_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[64:0];
            if (pending_results.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected result %h", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.centi !== want.centi)
                begin
                    n_errors++;
                    $display("%0t: temperature_centi expected %h actual %h",
                             $time, want.centi, got.centi);
                end
                if (got.pascal !== want.pascal)
                begin
                    n_errors++;
                    $display("%0t: pressure_pascal expected %h actual %h",
                             $time, want.pascal, got.pascal);
                end
                if (got.invalid !== want.invalid)
                begin
                    n_errors++;
                    $display("%0t: pressure_invalid expected %b actual %b",
                             $time, want.invalid, got.invalid);
                end
                if (m_axis_tdata[71:65] !== 7'd0)
                begin
                    n_errors++;
                    $display("%0t: pad bits expected 0 actual %h", $time, m_axis_tdata[71:65]);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= DOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Typical factory calibration words.
    localparam logic [47:0] TYP_T  = {16'hFC18, 16'h6A72, 16'h6E1C};
    localparam logic [63:0] TYP_PL = {16'h0B37, 16'hD0D0, 16'hD63F, 16'h8E6B};
    localparam logic [63:0] TYP_PH = {16'hE8C4, 16'h3A98, 16'hFFF9, 16'h008C};
    localparam logic [15:0] TYP_P9 = 16'h1770;

    row_t rows[$];

    function automatic row_t mk(input logic [19:0] rt, input logic [19:0] rp,
                                input bit he, input comp_t e);
        row_t r;
        r.rt = rt; r.rp = rp; r.has_exp = he; r.exp = e;
        return r;
    endfunction

    initial
    begin
        comp_t zero_invalid;
        int k, set;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TEMP;
        cfg_data = '0;
        cal_temp = '0; cal_plow = '0; cal_phigh = '0; cal_p9 = '0;
        n_errors = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all-zero calibration after reset, fine is zero, temperature is
        // 128>>8 = 0 and the pressure denominator is zero.
        zero_invalid = '{invalid: 1'b1, pascal: 32'd0, centi: 32'd0};
        rows.push_back(mk(20'h00000, 20'h00000, 1, zero_invalid));
        rows.push_back(mk(20'hFFFFF, 20'hFFFFF, 1, zero_invalid));
        rows.push_back(mk(20'h80000, 20'h00001, 1, zero_invalid));
        foreach (rows[i])
            send_pair(rows[i].rt, rows[i].rp, rows[i].has_exp, rows[i].exp);
        drain();

        rows.delete();
        load_cal(TYP_T, TYP_PL, TYP_PH, TYP_P9);
        rows.push_back(mk(20'h00000, 20'h00000, 0, '0));
        rows.push_back(mk(20'hFFFFF, 20'hFFFFF, 0, '0));
        rows.push_back(mk(20'h7E6F0, 20'h5A3C0, 0, '0));
        rows.push_back(mk(20'h80000, 20'h65A00, 0, '0));
        rows.push_back(mk(20'h00000, 20'hFFFFF, 0, '0));
        rows.push_back(mk(20'hFFFFF, 20'h00000, 0, '0));
        rows.push_back(mk(20'h55555, 20'hAAAAA, 0, '0));
        rows.push_back(mk(20'hAAAAA, 20'h55555, 0, '0));
        foreach (rows[i])
            send_pair(rows[i].rt, rows[i].rp, rows[i].has_exp, rows[i].exp);
        drain();

        // Extreme coefficients: large numerators and wrapping products.
        rows.delete();
        load_cal({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF},
                 {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
        rows.push_back(mk(20'h00000, 20'h00000, 0, '0));
        rows.push_back(mk(20'hFFFFF, 20'hFFFFF, 0, '0));
        rows.push_back(mk(20'h12345, 20'hFEDCB, 0, '0));
        rows.push_back(mk(20'hFEDCB, 20'h00000, 0, '0));
        foreach (rows[i])
            send_pair(rows[i].rt, rows[i].rp, rows[i].has_exp, rows[i].exp);
        drain();
        load_cal('1, '1, '1, 16'h7FFF);
        send_pair(20'h00000, 20'hFFFFF, 0, '0);
        send_pair(20'hFFFFF, 20'h00000, 0, '0);
        drain();

        // Random phases over several calibration sets.
        for (set = 0; set < 8; set++)
        begin
            case (set % 4)
                0: load_cal(TYP_T, TYP_PL, TYP_PH, TYP_P9);
                1: load_cal({TYP_T[47:16], 16'($urandom_range(20000, 35000))},
                            {TYP_PL[63:16], 16'($urandom_range(30000, 40000))},
                            {$urandom, $urandom}, 16'($urandom));
                2: load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                            {$urandom, $urandom}, 16'($urandom));
                default: load_cal(48'({$urandom, $urandom}), {48'($urandom), 16'd0},
                                  {$urandom, $urandom}, 16'($urandom));
            endcase
            no_idle = (set == 3);
            for (k = 0; k < N_RANDOM / 8; k++)
            begin
                if (k == 100)
                begin
                    // Hold off until the output side has caught up.
                    s_axis_tvalid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
                if ($urandom_range(3) != 0)
                    send_pair(20'($urandom_range(20'h60000, 20'h90000)),
                              20'($urandom_range(20'h40000, 20'h70000)), 0, '0);
                else
                    send_pair(20'($urandom), 20'($urandom), 0, '0);
            end
            drain();
        end
        no_idle = 1'b0;

        if (n_errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
